// ===== sv/mwas_pkg.sv =====
// shared constants, command codes and status bundle of the assignment solver
// no dependencies
package mwas_pkg;

  localparam int MAX_PER_SIDE = 16;
  localparam int IDX_W = $clog2(MAX_PER_SIDE);
  localparam int CNT_W = IDX_W + 1;
  localparam int ADDR_W = 2 * IDX_W;
  localparam int COORD_W = 16;
  localparam int TIME_W = 21;
  localparam int WORTH_W = 16;
  localparam int W_W = 32;
  localparam int LBL_W = 42;

  localparam logic signed [LBL_W-1:0] NO_SLACK = {2'b01, 40'd0};
  localparam logic [IDX_W:0] NO_ROW = '1;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_SETUP, OP_CLEAR, OP_FILL, OP_GAP, OP_RD_LBL, OP_LBL_ACC,
    OP_ROW, OP_AUG_INIT, OP_POP, OP_PROBE, OP_EVAL, OP_FLIP, OP_NEXT_X,
    OP_MIN_INIT, OP_MIN, OP_UPD, OP_OUT_INIT, OP_OUT_RD, OP_EMIT
  } op_t;

  typedef struct packed {
    logic nrow_zero;
    logic fill_last;
    logic lbl_last;
    logic stack_empty;
    logic top_exhausted;
    logic top_seen;
    logic d_zero;
    logic owner_free;
    logic flip_last;
    logic row_last;
    logic min_last;
    logic mn_stop;
    logic out_last;
  } stat_t;

endpackage

// ===== sv/mwas_ctrl.sv =====
// sequencer of the solver: load, weight fill, label init, path search, output
// depends on mwas_pkg
module mwas_ctrl import mwas_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  logic  final_node,
  input  stat_t st,
  output op_t   op,
  output logic  busy
);

  typedef enum logic [3:0] {
    S_IDLE, S_SETUP, S_FILL, S_GAP, S_LBL_RD, S_LBL_ACC, S_ROW, S_AUG_INIT,
    S_TOP, S_EVAL, S_FLIP, S_NEXT_ROW, S_MIN, S_MIN_CHK, S_OUT_RD, S_OUT_EM
  } state_t;

  state_t state;

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE:     if (start && final_node) state <= S_SETUP;
        S_SETUP:    state <= st.nrow_zero ? S_IDLE : S_FILL;
        S_FILL:     if (st.fill_last) state <= S_GAP;
        S_GAP:      state <= S_LBL_RD;
        S_LBL_RD:   state <= S_LBL_ACC;
        S_LBL_ACC:  state <= st.lbl_last ? S_ROW : S_LBL_RD;
        S_ROW:      state <= S_AUG_INIT;
        S_AUG_INIT: state <= S_TOP;
        S_TOP: begin
          priority if (st.stack_empty) state <= S_MIN;
          else if (st.top_exhausted || st.top_seen) state <= S_TOP;
          else state <= S_EVAL;
        end
        S_EVAL:     state <= (st.d_zero && st.owner_free) ? S_FLIP : S_TOP;
        S_FLIP:     if (st.flip_last) state <= S_NEXT_ROW;
        S_NEXT_ROW: state <= st.row_last ? S_OUT_RD : S_ROW;
        S_MIN:      if (st.min_last) state <= S_MIN_CHK;
        S_MIN_CHK:  state <= st.mn_stop ? S_NEXT_ROW : S_AUG_INIT;
        S_OUT_RD:   state <= S_OUT_EM;
        S_OUT_EM:   state <= st.out_last ? S_IDLE : S_OUT_RD;
        default:    state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    op = OP_NONE;
    unique case (state)
      S_IDLE:     if (start) op = OP_LOAD;
      S_SETUP:    op = st.nrow_zero ? OP_CLEAR : OP_SETUP;
      S_FILL:     op = OP_FILL;
      S_GAP:      op = OP_GAP;
      S_LBL_RD:   op = OP_RD_LBL;
      S_LBL_ACC:  op = OP_LBL_ACC;
      S_ROW:      op = OP_ROW;
      S_AUG_INIT: op = OP_AUG_INIT;
      S_TOP: begin
        priority if (st.stack_empty) op = OP_MIN_INIT;
        else if (st.top_exhausted) op = OP_POP;
        else op = OP_PROBE;
      end
      S_EVAL:     op = OP_EVAL;
      S_FLIP:     op = OP_FLIP;
      S_NEXT_ROW: op = st.row_last ? OP_OUT_INIT : OP_NEXT_X;
      S_MIN:      op = OP_MIN;
      S_MIN_CHK:  op = st.mn_stop ? OP_NONE : OP_UPD;
      S_OUT_RD:   op = OP_OUT_RD;
      S_OUT_EM:   op = st.out_last ? OP_CLEAR : OP_EMIT;
      default:    op = OP_NONE;
    endcase
  end

endmodule

// ===== sv/mwas_dp.sv =====
// datapath: node stores, weight memory, labels, slack, search stack, result regs
// depends on mwas_pkg
module mwas_dp import mwas_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  op_t                op,
  input  logic               is_task,
  input  logic [COORD_W-1:0] pos_x,
  input  logic [COORD_W-1:0] pos_y,
  input  logic [COORD_W-1:0] reach,
  input  logic [TIME_W-1:0]  start_time,
  input  logic [TIME_W-1:0]  stop_time,
  input  logic [WORTH_W-1:0] worth,
  output stat_t              st,
  output logic               done,
  output logic               row_is_task,
  output logic [IDX_W-1:0]   row_index,
  output logic [IDX_W-1:0]   col_index,
  output logic               paired,
  output logic [W_W-1:0]     pair_cost,
  output logic               last_row
);

  logic [COORD_W-1:0] wk_x [MAX_PER_SIDE];
  logic [COORD_W-1:0] wk_y [MAX_PER_SIDE];
  logic [COORD_W-1:0] wk_r [MAX_PER_SIDE];
  logic [TIME_W-1:0]  wk_s [MAX_PER_SIDE];
  logic [TIME_W-1:0]  wk_e [MAX_PER_SIDE];
  logic [WORTH_W-1:0] wk_v [MAX_PER_SIDE];
  logic [COORD_W-1:0] tk_x [MAX_PER_SIDE];
  logic [COORD_W-1:0] tk_y [MAX_PER_SIDE];
  logic [TIME_W-1:0]  tk_s [MAX_PER_SIDE];
  logic [TIME_W-1:0]  tk_e [MAX_PER_SIDE];
  logic [WORTH_W-1:0] tk_v [MAX_PER_SIDE];
  logic [CNT_W-1:0]   wk_cnt, tk_cnt;

  logic [W_W-1:0] wmem [MAX_PER_SIDE*MAX_PER_SIDE];
  logic [W_W-1:0] wdata;
  logic [ADDR_W-1:0] raddr;
  logic rd_en;

  logic rows_tasks;
  logic [CNT_W-1:0] nrow, ncol, cr, cc, x;
  logic [W_W-1:0] m;

  logic s1_v;
  logic [ADDR_W-1:0] s1_addr;
  logic [W_W-1:0] s1_dx2, s1_dy2, s1_r2, s1_prod;
  logic s1_win;

  logic signed [LBL_W-1:0] row_lbl [MAX_PER_SIDE];
  logic signed [LBL_W-1:0] col_lbl [MAX_PER_SIDE];
  logic signed [LBL_W-1:0] slack [MAX_PER_SIDE];
  logic signed [LBL_W-1:0] mn;
  logic [MAX_PER_SIDE-1:0] row_vis, col_vis;
  logic [IDX_W:0] col_own [MAX_PER_SIDE];
  logic [IDX_W:0] match [MAX_PER_SIDE];
  logic [IDX_W-1:0] st_row [MAX_PER_SIDE];
  logic [CNT_W-1:0] st_next [MAX_PER_SIDE];
  logic [IDX_W-1:0] st_took [MAX_PER_SIDE];
  logic [CNT_W-1:0] sp;
  logic [IDX_W-1:0] rr, ry;

  logic [IDX_W-1:0] top, top_row, spi, wi, ti, ci;
  logic [CNT_W-1:0] top_y;
  logic [COORD_W-1:0] dx, dy;
  logic signed [LBL_W-1:0] d;
  logic [IDX_W:0] owner, cur_match;
  logic can_push, mvalid;
  logic [W_W-1:0] mx;
  logic [W_W:0] dist2;
  logic emit_pending;

  assign top     = IDX_W'(sp - CNT_W'(1));
  assign spi     = sp[IDX_W-1:0];
  assign top_row = st_row[top];
  assign top_y   = st_next[top];
  assign wi      = rows_tasks ? cc[IDX_W-1:0] : cr[IDX_W-1:0];
  assign ti      = rows_tasks ? cr[IDX_W-1:0] : cc[IDX_W-1:0];
  assign ci      = cc[IDX_W-1:0];
  assign dx      = (wk_x[wi] > tk_x[ti]) ? wk_x[wi] - tk_x[ti] : tk_x[ti] - wk_x[wi];
  assign dy      = (wk_y[wi] > tk_y[ti]) ? wk_y[wi] - tk_y[ti] : tk_y[ti] - wk_y[wi];
  assign dist2   = {1'b0, s1_dx2} + {1'b0, s1_dy2};
  assign d       = row_lbl[rr] + col_lbl[ry] - $signed({{(LBL_W-W_W){1'b0}}, wdata});
  assign owner   = col_own[ry];
  assign can_push = (sp < CNT_W'(MAX_PER_SIDE)) && (owner < nrow);
  assign mx      = (wdata > m) ? wdata : m;
  assign cur_match = match[cr[IDX_W-1:0]];
  assign mvalid  = !cur_match[IDX_W];

  always_comb begin
    st.nrow_zero     = ((tk_cnt < wk_cnt) ? tk_cnt : wk_cnt) == '0;
    st.fill_last     = (cr == nrow - CNT_W'(1)) && (cc == ncol - CNT_W'(1));
    st.lbl_last      = st.fill_last;
    st.stack_empty   = (sp == '0);
    st.top_exhausted = (top_y >= ncol);
    st.top_seen      = col_vis[top_y[IDX_W-1:0]];
    st.d_zero        = (d == '0);
    st.owner_free    = owner[IDX_W];
    st.flip_last     = (sp == CNT_W'(1));
    st.row_last      = (x == nrow - CNT_W'(1));
    st.min_last      = (cc == ncol - CNT_W'(1));
    st.mn_stop       = (mn >= NO_SLACK) || (mn <= $signed(LBL_W'(0)));
    st.out_last      = (cr == nrow - CNT_W'(1));
  end

  always_comb begin
    rd_en = 1'b1;
    unique case (op)
      OP_RD_LBL: raddr = {cr[IDX_W-1:0], ci};
      OP_PROBE:  raddr = {top_row, top_y[IDX_W-1:0]};
      OP_OUT_RD: raddr = {cr[IDX_W-1:0], cur_match[IDX_W-1:0]};
      default: begin
        raddr = '0;
        rd_en = 1'b0;
      end
    endcase
  end

  // weight memory: one write from the fill pipe, one registered read
  always_ff @(posedge clk) begin
    if (s1_v) wmem[s1_addr] <= (dist2 <= {1'b0, s1_r2} && s1_win) ? s1_prod : '0;
    if (rd_en) wdata <= wmem[raddr];
  end

  // first stage of the weight pipe
  always_ff @(posedge clk) begin
    s1_addr <= {cr[IDX_W-1:0], ci};
    s1_dx2  <= dx * dx;
    s1_dy2  <= dy * dy;
    s1_r2   <= wk_r[wi] * wk_r[wi];
    s1_prod <= tk_v[ti] * wk_v[wi];
    s1_win  <= (wk_s[wi] < tk_e[ti]) && (tk_s[ti] < wk_e[wi]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wk_cnt <= '0;
      tk_cnt <= '0;
      sp     <= '0;
      s1_v   <= 1'b0;
      done   <= 1'b0;
    end else begin
      s1_v <= (op == OP_FILL);
      done <= (op == OP_EMIT) || (op == OP_CLEAR && emit_pending);
      unique case (op)
        OP_LOAD: begin
          if (is_task) begin
            if (tk_cnt < CNT_W'(MAX_PER_SIDE)) begin
              tk_x[tk_cnt[IDX_W-1:0]] <= pos_x;
              tk_y[tk_cnt[IDX_W-1:0]] <= pos_y;
              tk_s[tk_cnt[IDX_W-1:0]] <= start_time;
              tk_e[tk_cnt[IDX_W-1:0]] <= stop_time;
              tk_v[tk_cnt[IDX_W-1:0]] <= worth;
              tk_cnt <= tk_cnt + CNT_W'(1);
            end
          end else if (wk_cnt < CNT_W'(MAX_PER_SIDE)) begin
            wk_x[wk_cnt[IDX_W-1:0]] <= pos_x;
            wk_y[wk_cnt[IDX_W-1:0]] <= pos_y;
            wk_r[wk_cnt[IDX_W-1:0]] <= reach;
            wk_s[wk_cnt[IDX_W-1:0]] <= start_time;
            wk_e[wk_cnt[IDX_W-1:0]] <= stop_time;
            wk_v[wk_cnt[IDX_W-1:0]] <= worth;
            wk_cnt <= wk_cnt + CNT_W'(1);
          end
        end
        OP_SETUP: begin
          rows_tasks <= tk_cnt < wk_cnt;
          nrow <= (tk_cnt < wk_cnt) ? tk_cnt : wk_cnt;
          ncol <= (tk_cnt < wk_cnt) ? wk_cnt : tk_cnt;
          cr <= '0;
          cc <= '0;
        end
        OP_CLEAR: begin
          wk_cnt <= '0;
          tk_cnt <= '0;
        end
        OP_FILL, OP_MIN: begin
          if (op == OP_MIN && !col_vis[ci] && slack[ci] < mn) mn <= slack[ci];
          if (op == OP_FILL && cc == ncol - CNT_W'(1)) begin
            cc <= '0;
            cr <= cr + CNT_W'(1);
          end else begin
            cc <= cc + CNT_W'(1);
          end
        end
        OP_GAP: begin
          cr <= '0;
          cc <= '0;
          m  <= '0;
          x  <= '0;
          for (int i = 0; i < MAX_PER_SIDE; i++) begin
            col_lbl[i] <= '0;
            col_own[i] <= NO_ROW;
          end
        end
        OP_RD_LBL: ;
        OP_LBL_ACC: begin
          if (cc == ncol - CNT_W'(1)) begin
            row_lbl[cr[IDX_W-1:0]] <= $signed({{(LBL_W-W_W){1'b0}}, mx});
            match[cr[IDX_W-1:0]] <= NO_ROW;
            m  <= '0;
            cc <= '0;
            cr <= cr + CNT_W'(1);
          end else begin
            m  <= mx;
            cc <= cc + CNT_W'(1);
          end
        end
        OP_ROW: begin
          for (int i = 0; i < MAX_PER_SIDE; i++) slack[i] <= NO_SLACK;
        end
        OP_AUG_INIT: begin
          sp <= CNT_W'(1);
          st_row[0] <= x[IDX_W-1:0];
          st_next[0] <= '0;
          row_vis <= MAX_PER_SIDE'(1) << x[IDX_W-1:0];
          col_vis <= '0;
        end
        OP_POP: sp <= sp - CNT_W'(1);
        OP_PROBE: begin
          st_next[top] <= top_y + CNT_W'(1);
          rr <= top_row;
          ry <= top_y[IDX_W-1:0];
        end
        OP_EVAL: begin
          if (d == '0) begin
            col_vis[ry] <= 1'b1;
            st_took[top] <= ry;
            // column taken by another row: descend into that row
            if (!owner[IDX_W] && can_push) begin
              row_vis[owner[IDX_W-1:0]] <= 1'b1;
              st_row[spi] <= owner[IDX_W-1:0];
              st_next[spi] <= '0;
              sp <= sp + CNT_W'(1);
            end
          end else if (d < slack[ry]) begin
            slack[ry] <= d;
          end
        end
        OP_FLIP: begin
          col_own[st_took[top]] <= {1'b0, st_row[top]};
          match[st_row[top]] <= {1'b0, st_took[top]};
          sp <= sp - CNT_W'(1);
        end
        OP_NEXT_X: x <= x + CNT_W'(1);
        OP_MIN_INIT: begin
          mn <= NO_SLACK;
          cc <= '0;
        end
        OP_UPD: begin
          for (int i = 0; i < MAX_PER_SIDE; i++) begin
            if (row_vis[i]) row_lbl[i] <= row_lbl[i] - mn;
            if (col_vis[i]) col_lbl[i] <= col_lbl[i] + mn;
            else slack[i] <= slack[i] - mn;
          end
        end
        OP_OUT_INIT: cr <= '0;
        OP_OUT_RD: ;
        OP_EMIT: cr <= cr + CNT_W'(1);
        default: ;
      endcase
    end
  end

  // the last result is emitted in the same cycle that clears the batch
  always_ff @(posedge clk) begin
    if (rst) emit_pending <= 1'b0;
    else if (op == OP_OUT_RD) emit_pending <= 1'b1;
    else if (op == OP_EMIT || op == OP_CLEAR) emit_pending <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (op == OP_EMIT || (op == OP_CLEAR && emit_pending)) begin
      row_is_task <= rows_tasks;
      row_index   <= cr[IDX_W-1:0];
      col_index   <= mvalid ? cur_match[IDX_W-1:0] : '0;
      pair_cost   <= mvalid ? wdata : '0;
      paired      <= mvalid && (wdata != '0);
      last_row    <= (cr == nrow - CNT_W'(1));
    end
  end

endmodule

// ===== sv/max_weight_assignment_solver_top.sv =====
// channel   | ports                                          | handshake
// ----------+------------------------------------------------+------------------------
// node in   | is_task pos_x pos_y reach start_time stop_time | start high, busy low
//           | worth final_node                               |
// result    | row_is_task row_index col_index paired         | done high for one cycle
//           | pair_cost last_row                             |
// a node that is not final is stored and the sequencer stays idle; the final node starts
// the solve, during which busy stays high: weight fills, label reads, then per row a stack
// search over probes and a slack minimum per label update
// each result is read, then emitted; done cannot be held off
// synchronous active-high reset clears the node counts and the sequencer
// depends on mwas_pkg, mwas_ctrl, mwas_dp
module max_weight_assignment_solver_top import mwas_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               is_task,
  input  logic [COORD_W-1:0] pos_x,
  input  logic [COORD_W-1:0] pos_y,
  input  logic [COORD_W-1:0] reach,
  input  logic [TIME_W-1:0]  start_time,
  input  logic [TIME_W-1:0]  stop_time,
  input  logic [WORTH_W-1:0] worth,
  input  logic               final_node,
  output logic               done,
  output logic               row_is_task,
  output logic [IDX_W-1:0]   row_index,
  output logic [IDX_W-1:0]   col_index,
  output logic               paired,
  output logic [W_W-1:0]     pair_cost,
  output logic               last_row
);

  op_t   op;
  stat_t st;

  mwas_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .final_node (final_node),
    .st         (st),
    .op         (op),
    .busy       (busy)
  );

  mwas_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .op          (op),
    .is_task     (is_task),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .reach       (reach),
    .start_time  (start_time),
    .stop_time   (stop_time),
    .worth       (worth),
    .st          (st),
    .done        (done),
    .row_is_task (row_is_task),
    .row_index   (row_index),
    .col_index   (col_index),
    .paired      (paired),
    .pair_cost   (pair_cost),
    .last_row    (last_row)
  );

endmodule

// ===== verif/testbench.sv =====
// self-checking testbench for the maximum-weight assignment solver
// drives node items, predicts each batch's assignment and checks every result
// depends on mwas_pkg and max_weight_assignment_solver_top
`timescale 1ns / 1ps

module testbench;
  import mwas_pkg::*;

  localparam int LIMIT_CYCLES = 10000000;
  localparam int ITEM_TARGET  = 270;

  typedef struct {
    logic               is_task;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [COORD_W-1:0] reach;
    logic [TIME_W-1:0]  start_time;
    logic [TIME_W-1:0]  stop_time;
    logic [WORTH_W-1:0] worth;
    logic               final_node;
  } node_t;

  typedef struct {
    logic             row_is_task;
    logic [IDX_W-1:0] row_index;
    logic [IDX_W-1:0] col_index;
    logic             paired;
    logic [W_W-1:0]   pair_cost;
    logic             last_row;
  } match_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  node_t cur = '{default: '0};
  logic done, row_is_task, paired, last_row;
  logic [IDX_W-1:0] row_index, col_index;
  logic [W_W-1:0] pair_cost;

  node_t  pending_nodes[$];
  match_t expected_matches[$];
  int errors = 0;
  int cycles = 0;
  int batches = 0;
  int results_seen = 0;
  int gap = 0;
  bit drain_hold = 1'b0;
  bit paused_once = 1'b0;

  max_weight_assignment_solver_top i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .is_task(cur.is_task), .pos_x(cur.pos_x), .pos_y(cur.pos_y), .reach(cur.reach),
    .start_time(cur.start_time), .stop_time(cur.stop_time), .worth(cur.worth),
    .final_node(cur.final_node), .done(done), .row_is_task(row_is_task),
    .row_index(row_index), .col_index(col_index), .paired(paired),
    .pair_cost(pair_cost), .last_row(last_row)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  int unsigned wk_x[MAX_PER_SIDE], wk_y[MAX_PER_SIDE], wk_reach[MAX_PER_SIDE];
  int unsigned wk_start[MAX_PER_SIDE], wk_stop[MAX_PER_SIDE], wk_rate[MAX_PER_SIDE];
  int unsigned tk_x[MAX_PER_SIDE], tk_y[MAX_PER_SIDE];
  int unsigned tk_start[MAX_PER_SIDE], tk_stop[MAX_PER_SIDE], tk_pay[MAX_PER_SIDE];
  int wk_count = 0, tk_count = 0;
  longint row_lbl[MAX_PER_SIDE], col_lbl[MAX_PER_SIDE], col_slk[MAX_PER_SIDE];
  bit row_seen[MAX_PER_SIDE], col_seen[MAX_PER_SIDE];
  int col_own[MAX_PER_SIDE], row_col[MAX_PER_SIDE];
  int stk_row[MAX_PER_SIDE], stk_next[MAX_PER_SIDE], stk_took[MAX_PER_SIDE];
  bit rows_are_tasks;
  int n_rows, n_cols;
  localparam longint NONE_SLACK = longint'(1) << 40;

  function automatic int unsigned pair_weight(int w, int t);
    longint dx, dy, r;
    dx = (wk_x[w] > tk_x[t]) ? wk_x[w] - tk_x[t] : tk_x[t] - wk_x[w];
    dy = (wk_y[w] > tk_y[t]) ? wk_y[w] - tk_y[t] : tk_y[t] - wk_y[w];
    r = wk_reach[w];
    if (dx * dx + dy * dy > r * r) return 0;
    if (!(wk_start[w] < tk_stop[t] && tk_start[t] < wk_stop[w])) return 0;
    return tk_pay[t] * wk_rate[w];
  endfunction

  function automatic int unsigned grid_weight(int r, int c);
    return rows_are_tasks ? pair_weight(c, r) : pair_weight(r, c);
  endfunction

  // depth-first search for an augmenting path along tight edges
  function automatic bit find_path(int root);
    int sp, r, y, o;
    longint d;
    sp = 1;
    stk_row[0] = root;
    stk_next[0] = 0;
    row_seen[root] = 1'b1;
    while (sp > 0) begin
      r = stk_row[sp-1];
      y = stk_next[sp-1];
      if (y >= n_cols) begin
        sp--;
        continue;
      end
      stk_next[sp-1] = y + 1;
      if (col_seen[y]) continue;
      d = row_lbl[r] + col_lbl[y] - longint'(grid_weight(r, y));
      if (d == 0) begin
        col_seen[y] = 1'b1;
        stk_took[sp-1] = y;
        if (col_own[y] < 0) begin
          for (int k = sp - 1; k >= 0; k--) begin
            col_own[stk_took[k]] = stk_row[k];
            row_col[stk_row[k]] = stk_took[k];
          end
          return 1'b1;
        end
        if (sp < MAX_PER_SIDE) begin
          o = col_own[y];
          if (o >= n_rows) continue;
          row_seen[o] = 1'b1;
          stk_row[sp] = o;
          stk_next[sp] = 0;
          sp++;
        end
      end else if (d < col_slk[y]) begin
        col_slk[y] = d;
      end
    end
    return 1'b0;
  endfunction

  task automatic solve_assignment();
    longint m, mn;
    for (int r = 0; r < n_rows; r++) begin
      m = 0;
      for (int c = 0; c < n_cols; c++)
        if (longint'(grid_weight(r, c)) > m) m = grid_weight(r, c);
      row_lbl[r] = m;
      row_col[r] = -1;
    end
    for (int c = 0; c < n_cols; c++) begin
      col_lbl[c] = 0;
      col_own[c] = -1;
    end
    for (int x = 0; x < n_rows; x++) begin
      for (int c = 0; c < n_cols; c++) col_slk[c] = NONE_SLACK;
      forever begin
        for (int i = 0; i < MAX_PER_SIDE; i++) begin
          row_seen[i] = 1'b0;
          col_seen[i] = 1'b0;
        end
        if (find_path(x)) break;
        mn = NONE_SLACK;
        for (int c = 0; c < n_cols; c++)
          if (!col_seen[c] && col_slk[c] < mn) mn = col_slk[c];
        if (mn >= NONE_SLACK || mn <= 0) break;
        for (int r = 0; r < n_rows; r++)
          if (row_seen[r]) row_lbl[r] -= mn;
        for (int c = 0; c < n_cols; c++)
          if (col_seen[c]) col_lbl[c] += mn;
          else col_slk[c] -= mn;
      end
    end
  endtask

  task automatic predict_node(node_t nd);
    match_t mt;
    int c;
    int unsigned cost;
    if (nd.is_task) begin
      if (tk_count < MAX_PER_SIDE) begin
        tk_x[tk_count] = nd.pos_x;
        tk_y[tk_count] = nd.pos_y;
        tk_start[tk_count] = nd.start_time;
        tk_stop[tk_count] = nd.stop_time;
        tk_pay[tk_count] = nd.worth;
        tk_count++;
      end
    end else if (wk_count < MAX_PER_SIDE) begin
      wk_x[wk_count] = nd.pos_x;
      wk_y[wk_count] = nd.pos_y;
      wk_reach[wk_count] = nd.reach;
      wk_start[wk_count] = nd.start_time;
      wk_stop[wk_count] = nd.stop_time;
      wk_rate[wk_count] = nd.worth;
      wk_count++;
    end
    if (!nd.final_node) return;
    batches++;
    rows_are_tasks = tk_count < wk_count;
    n_rows = rows_are_tasks ? tk_count : wk_count;
    n_cols = rows_are_tasks ? wk_count : tk_count;
    if (n_rows > 0) begin
      solve_assignment();
      for (int r = 0; r < n_rows; r++) begin
        c = row_col[r];
        cost = (c >= 0 && c < n_cols) ? grid_weight(r, c) : 0;
        mt.row_is_task = rows_are_tasks;
        mt.row_index = r[IDX_W-1:0];
        mt.col_index = (c >= 0) ? c[IDX_W-1:0] : '0;
        mt.paired = cost > 0;
        mt.pair_cost = cost;
        mt.last_row = (r == n_rows - 1);
        expected_matches = {expected_matches, mt};
      end
    end
    wk_count = 0;
    tk_count = 0;
  endtask

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 65) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // driver: one item in flight on the ports, held until accepted
  always @(posedge clk) begin : drive_proc
    bit   accepted;
    bit   go;
    int   g;
    node_t nxt;
    accepted = 1'b0;
    go = 1'b0;
    g = gap;
    nxt = cur;
    if (!rst) begin
      if (start && !busy) begin
        accepted = 1'b1;
        predict_node(cur);
        if (cur.final_node && (!paused_once || $urandom_range(0, 3) == 0)) begin
          drain_hold = 1'b1;
          paused_once = 1'b1;
        end
        g = pick_gap();
      end
      if (drain_hold && expected_matches.size() == 0) drain_hold = 1'b0;
      if (start && !accepted) begin
        go = 1'b1;
      end else if (g > 0) begin
        g--;
      end else if (!drain_hold && pending_nodes.size() > 0) begin
        nxt = pending_nodes.pop_front();
        go = 1'b1;
      end
      gap = g;
      start <= go;
      cur <= nxt;
    end
  end

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch %s: got %0d, expected %0d at cycle %0d", field, got, want, cycles);
    errors++;
  endtask

  // monitor: results cannot be held off, each is checked in its done cycle
  always @(posedge clk) begin : check_proc
    match_t e;
    if (!rst && done) begin
      results_seen++;
      if (expected_matches.size() == 0) begin
        report_mismatch("unexpected row_index", row_index, -1);
      end else begin
        e = expected_matches.pop_front();
        if (row_is_task !== e.row_is_task)
          report_mismatch("row_is_task", row_is_task, e.row_is_task);
        if (row_index !== e.row_index) report_mismatch("row_index", row_index, e.row_index);
        if (col_index !== e.col_index) report_mismatch("col_index", col_index, e.col_index);
        if (paired !== e.paired) report_mismatch("paired", paired, e.paired);
        if (pair_cost !== e.pair_cost) report_mismatch("pair_cost", pair_cost, e.pair_cost);
        if (last_row !== e.last_row) report_mismatch("last_row", last_row, e.last_row);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("timeout with %0d results outstanding", expected_matches.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic node_t mk_node(int unsigned tsk, int unsigned x, int unsigned y,
                                    int unsigned rc, int unsigned st, int unsigned sp,
                                    int unsigned wv, int unsigned fin);
    node_t n;
    n.is_task = 1'(tsk); n.pos_x = COORD_W'(x); n.pos_y = COORD_W'(y);
    n.reach = COORD_W'(rc); n.start_time = TIME_W'(st); n.stop_time = TIME_W'(sp);
    n.worth = WORTH_W'(wv); n.final_node = 1'(fin);
    return n;
  endfunction

  function automatic void enqueue_node(node_t nd);
    pending_nodes = {pending_nodes, nd};
  endfunction

  // clustered nodes mostly reach each other; wild ones exercise every bit
  function automatic node_t rand_node(bit tsk, bit wild);
    int unsigned st;
    if (wild)
      return mk_node(tsk, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 0);
    st = $urandom_range(0, 4000);
    return mk_node(tsk, 30000 + $urandom_range(0, 400), 30000 + $urandom_range(0, 400),
                   $urandom_range(50, 700), st, st + $urandom_range(1, 3000),
                   $urandom, 0);
  endfunction

  task automatic add_batch(int nw, int nt, int wild_pct);
    node_t list[$];
    int k;
    for (int i = 0; i < nw; i++) list = {list, rand_node(1'b0, $urandom_range(0, 99) < wild_pct)};
    for (int i = 0; i < nt; i++) list = {list, rand_node(1'b1, $urandom_range(0, 99) < wild_pct)};
    for (int i = list.size() - 1; i > 0; i--) begin
      node_t tmp;
      k = $urandom_range(0, i);
      tmp = list[i]; list[i] = list[k]; list[k] = tmp;
    end
    list[list.size()-1].final_node = 1'b1;
    foreach (list[i]) enqueue_node(list[i]);
  endtask

  initial begin
    int p;
    // extremes of every field, strict and touching windows
    enqueue_node(mk_node(0, 0, 0, 16'hFFFF, 0, 21'h1FFFFF, 16'hFFFF, 0));
    enqueue_node(mk_node(0, 16'hFFFF, 16'hFFFF, 0, 0, 21'h1FFFFF, 0, 0));
    enqueue_node(mk_node(1, 16'hFFFF, 16'hFFFF, 0, 0, 21'h1FFFFF, 16'hFFFF, 0));
    enqueue_node(mk_node(1, 0, 0, 16'hFFFF, 100, 100, 16'h0100, 0));
    enqueue_node(mk_node(1, 5, 5, 0, 21'h1FFFFF, 21'h1FFFFF, 16'h8000, 1));
    // touching windows give zero weight, exact reach boundary counts
    enqueue_node(mk_node(0, 100, 100, 5, 10, 50, 16'h4000, 0));
    enqueue_node(mk_node(1, 103, 104, 0, 50, 90, 16'h0200, 0));
    enqueue_node(mk_node(1, 103, 104, 0, 49, 90, 16'h0300, 1));
    // workers outnumber tasks, so tasks are the rows
    enqueue_node(mk_node(0, 10, 10, 100, 0, 1000, 16'h1234, 0));
    enqueue_node(mk_node(0, 20, 20, 100, 0, 1000, 16'hFFFF, 0));
    enqueue_node(mk_node(0, 30, 30, 100, 0, 1000, 16'h0001, 0));
    enqueue_node(mk_node(1, 15, 15, 0, 500, 600, 16'hFFFF, 1));
    // one side empty: no results
    enqueue_node(mk_node(1, 1, 1, 1, 1, 2, 16'h0001, 0));
    enqueue_node(mk_node(1, 2, 2, 2, 1, 2, 16'h0002, 1));
    enqueue_node(mk_node(0, 7, 7, 7, 0, 9, 16'h0007, 1));
    // full worker side with one overflow worker dropped, final mark on the last shuffled node
    add_batch(17, 3, 0);
    while (pending_nodes.size() < ITEM_TARGET) begin
      p = $urandom_range(0, 99);
      if (p < 4) add_batch(16, 16, 0);
      else if (p < 8) add_batch($urandom_range(0, 2), $urandom_range(0, 2), 100);
      else add_batch($urandom_range(1, 5), $urandom_range(1, 5), 15);
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    while (pending_nodes.size() > 0 || start || busy || expected_matches.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
    $display("covered %0d batches and %0d checked results", batches, results_seen);
    if (errors == 0 && expected_matches.size() == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/mwas_pkg.sv
sv/mwas_ctrl.sv
sv/mwas_dp.sv
sv/max_weight_assignment_solver_top.sv
verif/testbench.sv
